[src/sobel_pkg.sv]
package sobel_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_W        = 12;
	localparam int POS_W        = 11;
	localparam int GRAD_W       = 11;
	localparam int SQ_W         = 20;
	localparam int ENERGY_W     = 16;
	localparam int MAX_WIDTH_D  = 2048;
	localparam int MAX_HEIGHT_D = 2048;
	localparam int MIN_DIM      = 3;
	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
	localparam logic [ENERGY_W-1:0] ENERGY_CLAMP = 16'd65025;
	localparam logic [ENERGY_W-1:0] ROOT_BIT_START = 16'h4000;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 32;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRAD,
		ST_SQR,
		ST_SUM,
		ST_ROOT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic square;
		logic sum;
		logic root;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic root_last;
		logic out_free;
	} status_t;

endpackage

[src/sobel_ram.sv]
module sobel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/sobel_ctrl.sv]
module sobel_ctrl import sobel_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_GRAD;
			end
			ST_GRAD: begin
				state_nxt = status.interior ? ST_SQR : ST_IDLE;
			end
			ST_SQR:  state_nxt = ST_SUM;
			ST_SUM:  state_nxt = ST_ROOT;
			ST_ROOT: begin
				if (status.root_last) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_GRAD: cmd.step   = 1'b1;
			ST_SQR:  cmd.square = 1'b1;
			ST_SUM:  cmd.sum    = 1'b1;
			ST_ROOT: cmd.root   = 1'b1;
			ST_EMIT: cmd.emit   = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[src/sobel_dp.sv]
module sobel_dp import sobel_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [PIX_W-1:0]   pixel,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   magnitude,
	output logic [POS_W-1:0]   out_row,
	output logic [POS_W-1:0]   out_col,
	output logic               last_of_frame
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WDW   = $clog2(MAX_WIDTH + 1);
	localparam int HDW   = $clog2(MAX_HEIGHT + 1);
	localparam int DW0   = (WDW > HDW) ? WDW : HDW;
	localparam int DIMW  = (DW0 > CFG_W) ? DW0 : CFG_W;
	localparam logic [DIMW-1:0] WMAX = DIMW'(MAX_WIDTH);
	localparam logic [DIMW-1:0] HMAX = DIMW'(MAX_HEIGHT);
	localparam logic [DIMW-1:0] DMIN = DIMW'(MIN_DIM);

	logic [CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] win_q [6];
	logic [2*PIX_W-1:0] ls_rdata;

	logic [DIMW-1:0] w_cfg, h_cfg, w_use, h_use, c_ext, r_ext, c_inc, r_inc;
	logic            interior, last_pos;
	logic [PIX_W-1:0] top, mid;

	logic signed [GRAD_W-1:0] gh, gv;
	logic signed [GRAD_W-1:0] gh_q, gv_q;
	logic signed [2*GRAD_W-1:0] gh_sq, gv_sq;
	logic [SQ_W-1:0]          ghsq_q, gvsq_q;
	logic [SQ_W:0]            energy;

	logic [ENERGY_W-1:0] x_q, res_q, bit_q;
	logic [ENERGY_W:0]   trial;

	logic             int_q, last_q;
	logic [POS_W-1:0] orow_q, ocol_q;

	logic             oval_q, olast_q;
	logic [PIX_W-1:0] omag_q;
	logic [POS_W-1:0] orow_out_q, ocol_out_q;

	sobel_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (cmd.step),
		.waddr (col_q),
		.wdata ({pix_q, mid}),
		.re    (cmd.load),
		.raddr (col_q),
		.rdata (ls_rdata)
	);

	assign top = ls_rdata[PIX_W-1:0];
	assign mid = ls_rdata[2*PIX_W-1:PIX_W];

	// dimensions in use, saturated into the legal range
	always_comb begin
		w_cfg = DIMW'(width_q);
		h_cfg = DIMW'(height_q);
		if (w_cfg < DMIN)      w_use = DMIN;
		else if (w_cfg > WMAX) w_use = WMAX;
		else                   w_use = w_cfg;
		if (h_cfg < DMIN)      h_use = DMIN;
		else if (h_cfg > HMAX) h_use = HMAX;
		else                   h_use = h_cfg;
		c_ext    = DIMW'(col_q);
		r_ext    = DIMW'(row_q);
		c_inc    = c_ext + DIMW'(1);
		r_inc    = r_ext + DIMW'(1);
		interior = (r_ext >= DIMW'(2)) && (c_ext >= DIMW'(2)) &&
		           (r_ext < h_use) && (c_ext < w_use);
		last_pos = (r_inc == h_use) && (c_inc == w_use);
	end

	// Sobel kernels over the window, left column c-2, right column c
	always_comb begin
		gh = ($signed({3'b000, win_q[0]}) - $signed({3'b000, top}))
		   + (($signed({3'b000, win_q[1]}) - $signed({3'b000, mid})) <<< 1)
		   + ($signed({3'b000, win_q[2]}) - $signed({3'b000, pix_q}));
		gv = ($signed({3'b000, win_q[0]}) - $signed({3'b000, win_q[2]}))
		   + (($signed({3'b000, win_q[3]}) - $signed({3'b000, win_q[5]})) <<< 1)
		   + ($signed({3'b000, top}) - $signed({3'b000, pix_q}));
		gh_sq  = gh_q * gh_q;
		gv_sq  = gv_q * gv_q;
		energy = {1'b0, ghsq_q} + {1'b0, gvsq_q};
		trial  = {1'b0, res_q} + {1'b0, bit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH)  width_q  <= cfg_data;
				if (cfg_index == REG_FRAME_HEIGHT) height_q <= cfg_data;
			end
			if (cmd.step) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top;
				win_q[4] <= mid;
				win_q[5] <= pix_q;
				if (c_inc >= w_use) begin
					col_q <= '0;
					row_q <= (r_inc >= h_use) ? '0 : RW'(r_inc);
				end else begin
					col_q <= CW'(c_inc);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) pix_q <= pixel;
		if (cmd.step) begin
			gh_q   <= gh;
			gv_q   <= gv;
			int_q  <= interior;
			last_q <= last_pos;
			orow_q <= POS_W'(row_q - RW'(1));
			ocol_q <= POS_W'(col_q - CW'(1));
		end
		if (cmd.square) begin
			ghsq_q <= gh_sq[SQ_W-1:0];
			gvsq_q <= gv_sq[SQ_W-1:0];
		end
		if (cmd.sum) begin
			x_q   <= (energy > {{(SQ_W+1-ENERGY_W){1'b0}}, ENERGY_CLAMP}) ?
			         ENERGY_CLAMP : energy[ENERGY_W-1:0];
			res_q <= '0;
			bit_q <= ROOT_BIT_START;
		end
		if (cmd.root) begin
			if ({1'b0, x_q} >= trial) begin
				x_q   <= x_q - trial[ENERGY_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.emit) begin
			omag_q     <= res_q[PIX_W-1:0];
			orow_out_q <= orow_q;
			ocol_out_q <= ocol_q;
			olast_q    <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.emit) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	assign status.interior  = interior;
	assign status.root_last = bit_q[0];
	assign status.out_free  = !oval_q || out_ready;

	assign out_valid     = oval_q;
	assign magnitude     = omag_q;
	assign out_row       = orow_out_q;
	assign out_col       = ocol_out_q;
	assign last_of_frame = olast_q;

endmodule

[src/sobel_edge_magnitude.sv]
// Pixels are handled one at a time: a new pixel is accepted only in the idle state,
// and interior pixels take longer than border pixels, since they also pass
// through the 8-step iterative square root.
// The output register frees the input side while a result waits.
// Reset (arst_n low, async): counters and window clear, registers 640 x 480.
module sobel_edge_magnitude import sobel_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [7:0] pixel
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // [7:0] magnitude, [18:8] out_row,
	                                              // [29:19] out_col, [31:30] zero
	output logic                   m_axis_tlast   // last_of_frame
);

	cmd_t             cmd;
	status_t          status;
	logic [PIX_W-1:0] magnitude;
	logic [POS_W-1:0] out_row, out_col;

	sobel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sobel_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel         (s_axis_tdata[PIX_W-1:0]),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.magnitude     (magnitude),
		.out_row       (out_row),
		.out_col       (out_col),
		.last_of_frame (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_col, out_row, magnitude};

endmodule

[sim/tb.sv]
module tb;
	import sobel_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] mag;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} edge_word_t;

	class magnitude_board;
		bit [CFG_W-1:0] width_reg;
		bit [CFG_W-1:0] height_reg;
		bit [PIX_W-1:0] upper_line [MAX_WIDTH_D];
		bit [PIX_W-1:0] middle_line [MAX_WIDTH_D];
		bit [PIX_W-1:0] win [6];
		int unsigned    col;
		int unsigned    row;
		edge_word_t     expected_mags [$];
		int             errors;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			col        = 0;
			row        = 0;
			errors     = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [CFG_W-1:0] val);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = val;
			end else begin
				height_reg = val;
			end
		endfunction

		function int unsigned span(bit [CFG_W-1:0] v, int unsigned hi);
			if (v < MIN_DIM)
				return MIN_DIM;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int unsigned cur_width();
			return span(width_reg, MAX_WIDTH_D);
		endfunction

		function bit [PIX_W-1:0] root_floor(int unsigned e);
			bit [PIX_W-1:0] r;
			bit [PIX_W-1:0] trial;
			r = '0;
			for (int b = PIX_W - 1; b >= 0; b--) begin
				trial = r | PIX_W'(1 << b);
				if (trial * trial <= e)
					r = trial;
			end
			return r;
		endfunction

		// accepted pixel: advance the window and queue the magnitude it completes
		function void take_pixel(bit [PIX_W-1:0] px);
			int unsigned w, h, c, r, e;
			int a00, a10, a20, a01, a21, top, mid, bot, gh, gv;
			edge_word_t res;
			w   = span(width_reg, MAX_WIDTH_D);
			h   = span(height_reg, MAX_HEIGHT_D);
			c   = col;
			r   = row;
			top = upper_line[c];
			mid = middle_line[c];
			bot = px;
			if (r >= 2 && c >= 2 && r < h && c < w) begin
				a00 = win[0];
				a10 = win[1];
				a20 = win[2];
				a01 = win[3];
				a21 = win[5];
				gh  = (a00 - top) + 2 * (a10 - mid) + (a20 - bot);
				gv  = (a00 - a20) + 2 * (a01 - a21) + (top - bot);
				e   = gh * gh + gv * gv;
				if (e > ENERGY_CLAMP)
					e = ENERGY_CLAMP;
				res.mag  = root_floor(e);
				res.row  = POS_W'(r - 1);
				res.col  = POS_W'(c - 1);
				res.last = (r == h - 1) && (c == w - 1);
				expected_mags.push_back(res);
			end
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = PIX_W'(top);
			win[4] = PIX_W'(mid);
			win[5] = PIX_W'(bot);
			upper_line[c]  = PIX_W'(mid);
			middle_line[c] = PIX_W'(bot);
			if (c + 1 >= w) begin
				col = 0;
				row = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col = c + 1;
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_magnitude(logic [TDATA_OUT_W-1:0] data, logic last);
			edge_word_t want;
			if (expected_mags.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %h tlast %b",
					$time, data, last);
				errors++;
			end else begin
				want = expected_mags.pop_front();
				compare_field("magnitude", want.mag, data[PIX_W-1:0]);
				compare_field("out_row", want.row, data[PIX_W +: POS_W]);
				compare_field("out_col", want.col, data[PIX_W + POS_W +: POS_W]);
				compare_field("last_of_frame", want.last, last);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	magnitude_board board = new;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int pixels_sent = 0;
	int pix_mode = 0;

	sobel_edge_magnitude u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_magnitude(m_axis_tdata, m_axis_tlast);
	end

	task automatic send_pixel(input bit [PIX_W-1:0] px);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		board.take_pixel(px);
		pixels_sent++;
	endtask

	// drain; border pixels give no word, so allow the latency once more
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.expected_mags.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input bit [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [PIX_W-1:0] pick_pixel();
		case (pix_mode)
			0: return PIX_W'($urandom_range(255));
			1: return $urandom_range(1) ? 8'd255 : 8'd0;
			default: return 8'd100 + PIX_W'($urandom_range(20));
		endcase
	endfunction

	task automatic finish_frame();
		do send_pixel(pick_pixel()); while (board.col != 0 || board.row != 0);
	endtask

	task automatic run_phase(input int send_pct, input int stall, input int quota);
		int start;
		bit [CFG_W-1:0] w, h;
		send_idle_pct = send_pct;
		stall_pct     = stall;
		start         = pixels_sent;
		while (pixels_sent - start < quota) begin
			settle();
			pix_mode = $urandom_range(2);
			if (board.col == 0 && board.row == 0) begin
				case ($urandom_range(9))
					0: w = CFG_W'($urandom_range(2));
					1: w = CFG_W'($urandom_range(17, 40));
					default: w = CFG_W'($urandom_range(3, 10));
				endcase
				case ($urandom_range(9))
					0: h = CFG_W'($urandom_range(2));
					1: h = CFG_W'($urandom_range(7, 14));
					default: h = CFG_W'($urandom_range(3, 6));
				endcase
				write_reg(REG_FRAME_WIDTH, w);
				write_reg(REG_FRAME_HEIGHT, h);
			end else begin
				// mid-frame: height may move freely, width never grows
				case ($urandom_range(2))
					0: write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(12)));
					1: write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(board.cur_width())));
					default: ;
				endcase
			end
			if ($urandom_range(7) == 0) begin
				repeat ($urandom_range(1, 30)) send_pixel(pick_pixel());
			end else begin
				finish_frame();
			end
		end
		settle();
	endtask

	initial begin
		bit [PIX_W-1:0] corner_frame [25];
		corner_frame = '{
			8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
			8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
			8'd0,   8'd1,   8'd254, 8'd128, 8'd127,
			8'd255, 8'd255, 8'd0,   8'd0,   8'd0,
			8'd255, 8'd170, 8'd85,  8'd0,   8'd255
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_FRAME_WIDTH, 12'd5);
		write_reg(REG_FRAME_HEIGHT, 12'd5);
		foreach (corner_frame[i])
			send_pixel(corner_frame[i]);
		settle();

		// smallest frame, both dimensions clamped up to the minimum
		pix_mode = 0;
		write_reg(REG_FRAME_WIDTH, 12'd1);
		write_reg(REG_FRAME_HEIGHT, 12'd0);
		finish_frame();
		settle();

		run_phase(0, 0, 325);
		run_phase(59, 0, 325);
		run_phase(0, 59, 325);
		run_phase(19, 19, 325);

		if (board.errors == 0 && board.expected_mags.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
